// ===== rtl/pied_pkg.sv =====
// Shared types, codes and defaults for the priority interrupt event dispatcher.
package pied_pkg;

   localparam int NUM_SETS_DEF    = 4;
   localparam int NUM_LEVELS_DEF  = 4;
   localparam int TABLE_DEPTH_DEF = 16;

   localparam int HANDLE_W    = 30;
   localparam int PRIO_W      = 3;
   localparam int WORD_W      = 32;
   localparam int MAX_WORDS   = 4;
   localparam int MAX_RESULTS = 16;
   localparam logic [HANDLE_W-1:0] HANDLE_MAX = 30'h3FFF_FFFF;

   localparam logic [2:0] MODE_SUBSCRIBE   = 3'd0;
   localparam logic [2:0] MODE_ENABLE      = 3'd1;
   localparam logic [2:0] MODE_DISABLE     = 3'd2;
   localparam logic [2:0] MODE_UNSUBSCRIBE = 3'd3;
   localparam logic [2:0] MODE_INTERRUPT   = 3'd4;

   localparam logic [1:0] KIND_DONE     = 2'd0;
   localparam logic [1:0] KIND_MATCH    = 2'd1;
   localparam logic [1:0] KIND_NO_MATCH = 2'd2;

   localparam logic [1:0] ERR_OK        = 2'd0;
   localparam logic [1:0] ERR_BAD_PRIO  = 2'd1;
   localparam logic [1:0] ERR_NOT_FOUND = 2'd2;
   localparam logic [1:0] ERR_FULL      = 2'd3;

   typedef struct packed {
      logic [2:0]          mode;
      logic [PRIO_W-1:0]   priority_req;
      logic [HANDLE_W-1:0] handle;
      logic [WORD_W-1:0]   word_0;
      logic [WORD_W-1:0]   word_1;
      logic [WORD_W-1:0]   word_2;
      logic [WORD_W-1:0]   word_3;
   } req_type;

   typedef struct packed {
      logic [1:0]          kind;
      logic [1:0]          error_code;
      logic [HANDLE_W-1:0] out_handle;
      logic [PRIO_W-1:0]   out_priority;
      logic [WORD_W-1:0]   evt_0;
      logic [WORD_W-1:0]   evt_1;
      logic [WORD_W-1:0]   evt_2;
      logic [WORD_W-1:0]   evt_3;
      logic                last;
   } rsp_type;

endpackage

// ===== rtl/priority_interrupt_event_dispatcher.sv =====
// Top level of the priority interrupt event dispatcher.
//
// The block keeps a table of up to TABLE_DEPTH subscribers in one RAM (handle,
// level, one mask word per status set) and the insertion order, valid bits,
// per-level enable masks and hardware mask in flops. One request is worked at
// a time; req_ready is high only while idle. Enable, disable and unsubscribe
// search the table in insertion order, a RAM read and then a compare for each
// entry visited. An interrupt tests the enable mask of each level in turn, and
// for each level that is hit it walks the table in the same way. Matches come
// out in level order, then insertion order, at most 16 of them, the final one
// flagged by last; an interrupt with no match gives one no-match response.
// Mode codes 5 to 7 are taken and dropped. A finished response sits in an
// output register, and the walk stalls only when a new response is due while
// that register is still held.
module priority_interrupt_event_dispatcher #(
   parameter int NUM_SETS    = pied_pkg::NUM_SETS_DEF,
   parameter int NUM_LEVELS  = pied_pkg::NUM_LEVELS_DEF,
   parameter int TABLE_DEPTH = pied_pkg::TABLE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pied_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pied_pkg::rsp_type rsp_data
);

   localparam int SW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW   = $clog2(TABLE_DEPTH + 1);
   localparam int LW   = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
   localparam int LVW  = $clog2(NUM_LEVELS + 1);
   localparam int WW   = pied_pkg::WORD_W;
   localparam int MW   = NUM_SETS * WW;
   localparam int EW   = pied_pkg::HANDLE_W + pied_pkg::PRIO_W + MW;
   localparam int NW   = $clog2(pied_pkg::MAX_RESULTS + 1);

   // controller states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CMD  = 3'd1;
   localparam logic [2:0] S_RD   = 3'd2;
   localparam logic [2:0] S_EV   = 3'd3;
   localparam logic [2:0] S_LV   = 3'd4;
   localparam logic [2:0] S_END  = 3'd5;

   logic [2:0]             state_ff, state_in;
   pied_pkg::req_type      req_ff, req_in;
   logic [CW-1:0]          k_ff, k_in;
   logic [LVW-1:0]         lv_ff, lv_in;
   logic [NW-1:0]          n_ff, n_in;
   logic [SW-1:0]          slot_ff, slot_in;
   logic                   pend_valid_ff, pend_valid_in;
   pied_pkg::rsp_type      pend_ff, pend_in;
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [SW-1:0]          order_ff [TABLE_DEPTH];
   logic [SW-1:0]          order_in [TABLE_DEPTH];
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic [WW-1:0]          lem_ff [NUM_LEVELS][NUM_SETS];
   logic [WW-1:0]          lem_in [NUM_LEVELS][NUM_SETS];
   logic [WW-1:0]          hw_ff [NUM_SETS];
   logic [WW-1:0]          hw_in [NUM_SETS];
   logic [pied_pkg::HANDLE_W-1:0] nh_ff, nh_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   pied_pkg::rsp_type      rsp_ff, rsp_in;

   // table RAM
   logic                   ram_we;
   logic [SW-1:0]          ram_waddr;
   logic [EW-1:0]          ram_wdata;
   logic                   ram_re;
   logic [SW-1:0]          ram_raddr;
   logic [EW-1:0]          ram_rdata;

   pied_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_table (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   logic [WW-1:0]                 wd [pied_pkg::MAX_WORDS];
   logic [pied_pkg::HANDLE_W-1:0] rd_handle;
   logic [pied_pkg::PRIO_W-1:0]   rd_prio;
   logic [WW-1:0]                 rd_mask [NUM_SETS];
   logic [WW-1:0]                 evt [pied_pkg::MAX_WORDS];
   logic                          hit;
   logic                          need;
   logic                          out_free;
   logic [SW-1:0]                 free_slot;
   logic                          free_found;
   logic [LW-1:0]                 lv_idx;
   logic [LW-1:0]                 rd_lv;
   logic [SW-1:0]                 k_idx;

   assign wd[0] = req_ff.word_0;
   assign wd[1] = req_ff.word_1;
   assign wd[2] = req_ff.word_2;
   assign wd[3] = req_ff.word_3;

   assign rd_handle = ram_rdata[EW-1 -: pied_pkg::HANDLE_W];
   assign rd_prio   = ram_rdata[MW +: pied_pkg::PRIO_W];
   assign lv_idx    = lv_ff[LW-1:0];
   assign rd_lv     = rd_prio[LW-1:0];
   assign k_idx     = k_ff[SW-1:0];
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      for (int i = 0; i < NUM_SETS; i++) begin
         rd_mask[i] = ram_rdata[i*WW +: WW];
      end
      hit = 1'b0;
      for (int i = 0; i < pied_pkg::MAX_WORDS; i++) begin
         evt[i] = '0;
      end
      for (int i = 0; i < NUM_SETS; i++) begin
         evt[i] = rd_mask[i] & wd[i];
         if (evt[i] != '0) begin
            hit = 1'b1;
         end
      end
      need = 1'b0;
      for (int i = 0; i < NUM_SETS; i++) begin
         if ((lem_ff[lv_idx][i] & wd[i]) != '0) begin
            need = 1'b1;
         end
      end
      free_found = 1'b0;
      free_slot  = '0;
      for (int s = 0; s < TABLE_DEPTH; s++) begin
         if (!free_found && !valid_ff[s]) begin
            free_found = 1'b1;
            free_slot  = SW'(s);
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      k_in          = k_ff;
      lv_in         = lv_ff;
      n_in          = n_ff;
      slot_in       = slot_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      valid_in      = valid_ff;
      order_in      = order_ff;
      cnt_in        = cnt_ff;
      lem_in        = lem_ff;
      hw_in         = hw_ff;
      nh_in         = nh_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      ram_we        = 1'b0;
      ram_waddr     = free_slot;
      ram_wdata     = {nh_ff, req_ff.priority_req, MW'({wd[3], wd[2], wd[1], wd[0]})};
      ram_re        = 1'b0;
      ram_raddr     = order_ff[k_idx];

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in        = req_data;
               k_in          = '0;
               lv_in         = '0;
               n_in          = '0;
               pend_valid_in = 1'b0;
               case (req_data.mode)
                  pied_pkg::MODE_SUBSCRIBE:   state_in = S_CMD;
                  pied_pkg::MODE_ENABLE,
                  pied_pkg::MODE_DISABLE,
                  pied_pkg::MODE_UNSUBSCRIBE: state_in = S_RD;
                  pied_pkg::MODE_INTERRUPT:   state_in = S_LV;
                  default:                    state_in = S_IDLE;
               endcase
            end
         end
         S_CMD: begin
            pend_in            = '0;
            pend_valid_in      = 1'b1;
            pend_in.kind       = pied_pkg::KIND_DONE;
            state_in           = S_END;
            if (32'(req_ff.priority_req) >= NUM_LEVELS) begin
               pend_in.error_code = pied_pkg::ERR_BAD_PRIO;
            end else if (32'(cnt_ff) >= TABLE_DEPTH || !free_found) begin
               pend_in.error_code = pied_pkg::ERR_FULL;
            end else begin
               ram_we                  = 1'b1;
               valid_in[free_slot]     = 1'b1;
               order_in[cnt_ff[SW-1:0]] = free_slot;
               cnt_in                  = cnt_ff + CW'(1);
               nh_in = (nh_ff == pied_pkg::HANDLE_MAX) ? pied_pkg::HANDLE_W'(1)
                                                       : nh_ff + pied_pkg::HANDLE_W'(1);
               for (int i = 0; i < NUM_SETS; i++) begin
                  lem_in[req_ff.priority_req[LW-1:0]][i] =
                     lem_ff[req_ff.priority_req[LW-1:0]][i] | wd[i];
                  hw_in[i] = hw_ff[i] | wd[i];
               end
               pend_in.out_handle = nh_ff;
            end
         end
         S_RD: begin
            if (k_ff < cnt_ff) begin
               ram_re   = 1'b1;
               slot_in  = order_ff[k_idx];
               state_in = S_EV;
            end else if (req_ff.mode == pied_pkg::MODE_INTERRUPT) begin
               lv_in    = lv_ff + LVW'(1);
               state_in = S_LV;
            end else begin
               pend_in            = '0;
               pend_in.kind       = pied_pkg::KIND_DONE;
               pend_in.error_code = pied_pkg::ERR_NOT_FOUND;
               pend_valid_in      = 1'b1;
               state_in           = S_END;
            end
         end
         S_EV: begin
            if (req_ff.mode == pied_pkg::MODE_INTERRUPT) begin
               if (valid_ff[slot_ff] && rd_prio == pied_pkg::PRIO_W'(lv_ff) && hit &&
                   n_ff < NW'(pied_pkg::MAX_RESULTS)) begin
                  if (!pend_valid_ff || out_free) begin
                     if (pend_valid_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = pend_ff;
                     end
                     pend_in              = '0;
                     pend_in.kind         = pied_pkg::KIND_MATCH;
                     pend_in.out_handle   = rd_handle;
                     pend_in.out_priority = pied_pkg::PRIO_W'(lv_ff);
                     pend_in.evt_0        = evt[0];
                     pend_in.evt_1        = evt[1];
                     pend_in.evt_2        = evt[2];
                     pend_in.evt_3        = evt[3];
                     pend_valid_in        = 1'b1;
                     n_in                 = n_ff + NW'(1);
                     k_in                 = k_ff + CW'(1);
                     state_in             = S_RD;
                  end
               end else begin
                  k_in     = k_ff + CW'(1);
                  state_in = S_RD;
               end
            end else if (valid_ff[slot_ff] && rd_handle == req_ff.handle) begin
               for (int i = 0; i < NUM_SETS; i++) begin
                  if (req_ff.mode == pied_pkg::MODE_ENABLE) begin
                     lem_in[rd_lv][i] = lem_ff[rd_lv][i] | rd_mask[i];
                     hw_in[i]         = hw_ff[i] | rd_mask[i];
                  end else begin
                     lem_in[rd_lv][i] = lem_ff[rd_lv][i] & ~rd_mask[i];
                     hw_in[i]         = hw_ff[i] & ~rd_mask[i];
                  end
               end
               if (req_ff.mode == pied_pkg::MODE_UNSUBSCRIBE) begin
                  valid_in[slot_ff] = 1'b0;
                  for (int j = 0; j + 1 < TABLE_DEPTH; j++) begin
                     if (CW'(j) >= k_ff) begin
                        order_in[j] = order_ff[j+1];
                     end
                  end
                  cnt_in = cnt_ff - CW'(1);
               end
               pend_in       = '0;
               pend_in.kind  = pied_pkg::KIND_DONE;
               pend_valid_in = 1'b1;
               state_in      = S_END;
            end else begin
               k_in     = k_ff + CW'(1);
               state_in = S_RD;
            end
         end
         S_LV: begin
            if (lv_ff == LVW'(NUM_LEVELS)) begin
               state_in = S_END;
            end else if (need) begin
               k_in     = '0;
               state_in = S_RD;
            end else begin
               lv_in = lv_ff + LVW'(1);
            end
         end
         S_END: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (pend_valid_ff) begin
                  rsp_in = pend_ff;
               end else begin
                  rsp_in      = '0;
                  rsp_in.kind = pied_pkg::KIND_NO_MATCH;
               end
               rsp_in.last   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pend_valid_ff <= 1'b0;
         valid_ff      <= '0;
         cnt_ff        <= '0;
         nh_ff         <= pied_pkg::HANDLE_W'(1);
         rsp_valid_ff  <= 1'b0;
         for (int l = 0; l < NUM_LEVELS; l++) begin
            for (int i = 0; i < NUM_SETS; i++) begin
               lem_ff[l][i] <= '0;
            end
         end
         for (int i = 0; i < NUM_SETS; i++) begin
            hw_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         valid_ff      <= valid_in;
         cnt_ff        <= cnt_in;
         nh_ff         <= nh_in;
         rsp_valid_ff  <= rsp_valid_in;
         lem_ff        <= lem_in;
         hw_ff         <= hw_in;
      end
      req_ff   <= req_in;
      k_ff     <= k_in;
      lv_ff    <= lv_in;
      n_ff     <= n_in;
      slot_ff  <= slot_in;
      pend_ff  <= pend_in;
      order_ff <= order_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // fill count tracks the valid bits
   a_count_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == 32'(cnt_ff))
      else $error("entry count out of step with valid bits");

   // a compare step always follows its RAM read
   a_eval_after_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EV |-> $past(state_ff) == S_RD || $past(state_ff) == S_EV)
      else $error("compare step without a table read");

   // nothing is held back when a new request is taken
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !pend_valid_ff)
      else $error("pending response left over at request accept");
`endif

endmodule

// ===== rtl/pied_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pied_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic                                 rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== tb/sv/priority_interrupt_event_dispatcher_tb.sv =====
// Self-checking testbench for the priority interrupt event dispatcher.
`timescale 1ns / 1ps

module priority_interrupt_event_dispatcher_tb;

   localparam int LEVELS = pied_pkg::NUM_LEVELS_DEF;
   localparam int DEPTH  = pied_pkg::TABLE_DEPTH_DEF;
   localparam int SETS   = pied_pkg::NUM_SETS_DEF;
   localparam int HW     = pied_pkg::HANDLE_W;
   localparam int WW     = pied_pkg::WORD_W;
   localparam int STALL_LIMIT = 4000;
   localparam int RANDOM_ITEMS = 200;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   pied_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   pied_pkg::rsp_type rsp_data;

   priority_interrupt_event_dispatcher dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   // predictor's copy of the subscriber table
   logic          sub_valid [DEPTH];
   logic [1:0]    sub_level [DEPTH];
   logic [HW-1:0] sub_handle [DEPTH];
   logic [WW-1:0] sub_mask [DEPTH][SETS];
   int            sub_order [DEPTH];
   int            sub_count;
   logic [WW-1:0] level_en [LEVELS][SETS];
   logic [WW-1:0] hw_en [SETS];
   logic [HW-1:0] handle_next;

   pied_pkg::req_type pending_reqs [$];
   pied_pkg::rsp_type expected_rsps [$];
   logic [HW-1:0]     issued_handles [$];

   int  fail_count = 0;
   int  idle_phase;   // 0: receiver idles more, 1: sender idles more, 2: none
   int  quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic pied_pkg::rsp_type blank_rsp(logic [1:0] k, logic [1:0] e);
      pied_pkg::rsp_type r;
      r = '0;
      r.kind = k;
      r.error_code = e;
      r.last = 1'b1;
      return r;
   endfunction

   function automatic logic [WW-1:0] word_of(pied_pkg::req_type q, int i);
      case (i)
         0: return q.word_0;
         1: return q.word_1;
         2: return q.word_2;
         default: return q.word_3;
      endcase
   endfunction

   // Clears the table copy to its post-reset contents.
   task automatic reset_model();
      sub_count = 0;
      handle_next = HW'(1);
      issued_handles.delete();
      for (int s = 0; s < DEPTH; s++) sub_valid[s] = 1'b0;
      for (int l = 0; l < LEVELS; l++)
         for (int i = 0; i < SETS; i++) level_en[l][i] = '0;
      for (int i = 0; i < SETS; i++) hw_en[i] = '0;
   endtask

   // Updates the table copy and queues the responses one request produces.
   task automatic predict_dispatch(pied_pkg::req_type q);
      int s;
      int pos;
      int n;
      bit hit;
      bit need;
      logic [WW-1:0] ev [SETS];
      pied_pkg::rsp_type r;
      case (q.mode)
         pied_pkg::MODE_SUBSCRIBE: begin
            if (q.priority_req >= LEVELS) begin
               expected_rsps.push_back(blank_rsp(pied_pkg::KIND_DONE, pied_pkg::ERR_BAD_PRIO));
            end else if (sub_count >= DEPTH) begin
               expected_rsps.push_back(blank_rsp(pied_pkg::KIND_DONE, pied_pkg::ERR_FULL));
            end else begin
               s = 0;
               while (sub_valid[s]) s++;
               sub_valid[s] = 1'b1;
               sub_level[s] = q.priority_req[1:0];
               sub_handle[s] = handle_next;
               for (int i = 0; i < SETS; i++) begin
                  sub_mask[s][i] = word_of(q, i);
                  level_en[sub_level[s]][i] |= sub_mask[s][i];
                  hw_en[i] |= sub_mask[s][i];
               end
               sub_order[sub_count] = s;
               sub_count++;
               r = blank_rsp(pied_pkg::KIND_DONE, pied_pkg::ERR_OK);
               r.out_handle = handle_next;
               expected_rsps.push_back(r);
               issued_handles.push_back(handle_next);
               handle_next = (handle_next == pied_pkg::HANDLE_MAX) ? HW'(1)
                                                                    : handle_next + HW'(1);
            end
         end
         pied_pkg::MODE_ENABLE, pied_pkg::MODE_DISABLE, pied_pkg::MODE_UNSUBSCRIBE: begin
            pos = -1;
            for (int k = 0; k < sub_count; k++)
               if (pos < 0 && sub_valid[sub_order[k]] &&
                   sub_handle[sub_order[k]] == q.handle)
                  pos = k;
            if (pos < 0) begin
               expected_rsps.push_back(blank_rsp(pied_pkg::KIND_DONE, pied_pkg::ERR_NOT_FOUND));
            end else begin
               s = sub_order[pos];
               for (int i = 0; i < SETS; i++) begin
                  if (q.mode == pied_pkg::MODE_ENABLE) begin
                     level_en[sub_level[s]][i] |= sub_mask[s][i];
                     hw_en[i] |= sub_mask[s][i];
                  end else begin
                     level_en[sub_level[s]][i] &= ~sub_mask[s][i];
                     hw_en[i] &= ~sub_mask[s][i];
                  end
               end
               if (q.mode == pied_pkg::MODE_UNSUBSCRIBE) begin
                  sub_valid[s] = 1'b0;
                  for (int k = pos; k + 1 < sub_count; k++) sub_order[k] = sub_order[k + 1];
                  sub_count--;
               end
               expected_rsps.push_back(blank_rsp(pied_pkg::KIND_DONE, pied_pkg::ERR_OK));
            end
         end
         pied_pkg::MODE_INTERRUPT: begin
            n = 0;
            for (int lv = 0; lv < LEVELS; lv++) begin
               need = 0;
               for (int i = 0; i < SETS; i++)
                  if ((level_en[lv][i] & word_of(q, i)) != 0) need = 1;
               if (need) begin
                  for (int k = 0; k < sub_count; k++) begin
                     s = sub_order[k];
                     if (sub_valid[s] && sub_level[s] == lv) begin
                        hit = 0;
                        for (int i = 0; i < SETS; i++) begin
                           ev[i] = sub_mask[s][i] & word_of(q, i);
                           if (ev[i] != 0) hit = 1;
                        end
                        if (hit && n < pied_pkg::MAX_RESULTS) begin
                           r = '0;
                           r.kind = pied_pkg::KIND_MATCH;
                           r.out_handle = sub_handle[s];
                           r.out_priority = pied_pkg::PRIO_W'(lv);
                           r.evt_0 = ev[0];
                           r.evt_1 = ev[1];
                           r.evt_2 = ev[2];
                           r.evt_3 = ev[3];
                           expected_rsps.push_back(r);
                           n++;
                        end
                     end
                  end
               end
            end
            if (n == 0) begin
               expected_rsps.push_back(blank_rsp(pied_pkg::KIND_NO_MATCH, pied_pkg::ERR_OK));
            end else begin
               r = expected_rsps.pop_back();
               r.last = 1'b1;
               expected_rsps.push_back(r);
            end
         end
         default: ;  // modes 5..7 dropped, no response
      endcase
   endtask

   // Driver: presents queued requests, holds them until accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
         reset_model();
      end else if (req_valid && req_ready) begin
         predict_dispatch(req_data);
         if (pending_reqs.size() > 0 && !(idle_phase == 0 && $urandom_range(99) < 36)
             && !(idle_phase == 1 && $urandom_range(99) < 45)) begin
            req_data <= pending_reqs.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end else if (!req_valid && pending_reqs.size() > 0) begin
         if (!(idle_phase == 0 && $urandom_range(99) < 36)
             && !(idle_phase == 1 && $urandom_range(99) < 45)) begin
            req_data <= pending_reqs.pop_front();
            req_valid <= 1'b1;
         end
      end
   end

   // Monitor: compares each accepted response with the oldest expectation.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $error("unexpected response %p", rsp_data);
               fail_count++;
            end else begin
               pied_pkg::rsp_type e;
               e = expected_rsps.pop_front();
               if (rsp_data.kind !== e.kind) begin
                  $error("kind exp %0d got %0d", e.kind, rsp_data.kind); fail_count++;
               end
               if (rsp_data.error_code !== e.error_code) begin
                  $error("error_code exp %0d got %0d", e.error_code, rsp_data.error_code);
                  fail_count++;
               end
               if (rsp_data.out_handle !== e.out_handle) begin
                  $error("out_handle exp %h got %h", e.out_handle, rsp_data.out_handle);
                  fail_count++;
               end
               if (rsp_data.out_priority !== e.out_priority) begin
                  $error("out_priority exp %0d got %0d", e.out_priority,
                         rsp_data.out_priority);
                  fail_count++;
               end
               if (rsp_data.evt_0 !== e.evt_0) begin
                  $error("evt_0 exp %h got %h", e.evt_0, rsp_data.evt_0); fail_count++;
               end
               if (rsp_data.evt_1 !== e.evt_1) begin
                  $error("evt_1 exp %h got %h", e.evt_1, rsp_data.evt_1); fail_count++;
               end
               if (rsp_data.evt_2 !== e.evt_2) begin
                  $error("evt_2 exp %h got %h", e.evt_2, rsp_data.evt_2); fail_count++;
               end
               if (rsp_data.evt_3 !== e.evt_3) begin
                  $error("evt_3 exp %h got %h", e.evt_3, rsp_data.evt_3); fail_count++;
               end
               if (rsp_data.last !== e.last) begin
                  $error("last exp %0d got %0d", e.last, rsp_data.last); fail_count++;
               end
            end
         end
         case (idle_phase)
            0: rsp_ready <= ($urandom_range(99) >= 45);
            1: rsp_ready <= ($urandom_range(99) >= 36);
            default: rsp_ready <= 1'b1;
         endcase
      end
   end

   // Watchdog: counts cycles with no handshake on either side.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   function automatic pied_pkg::req_type make_req(logic [2:0] m, logic [2:0] p,
                                                  logic [HW-1:0] h,
                                                  logic [WW-1:0] w0, logic [WW-1:0] w1,
                                                  logic [WW-1:0] w2, logic [WW-1:0] w3);
      pied_pkg::req_type q;
      q.mode = m; q.priority_req = p; q.handle = h;
      q.word_0 = w0; q.word_1 = w1; q.word_2 = w2; q.word_3 = w3;
      return q;
   endfunction

   // Handle that is usually live, sometimes stale or unknown.
   function automatic logic [HW-1:0] pick_handle();
      int r;
      r = $urandom_range(9);
      if (issued_handles.size() == 0 || r == 0) return HW'($urandom);
      if (r == 1) return HW'(0);
      return issued_handles[$urandom_range(issued_handles.size() - 1)];
   endfunction

   // Sparse random word so several subscribers share and miss bits.
   function automatic logic [WW-1:0] sparse_word();
      case ($urandom_range(3))
         0: return '0;
         1: return 32'h1 << $urandom_range(31);
         2: return $urandom & $urandom & $urandom;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      pied_pkg::req_type q;
      int pick;
      reset = 1'b1;
      idle_phase = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, bad priority, unknown handle, unused modes
      pending_reqs.push_back(make_req(pied_pkg::MODE_INTERRUPT, 3'd0, '0, '1, '1, '1, '1));
      pending_reqs.push_back(make_req(pied_pkg::MODE_SUBSCRIBE, 3'd7, '0, '1, '1, '1, '1));
      pending_reqs.push_back(make_req(pied_pkg::MODE_SUBSCRIBE, 3'd4, '0,
                                      32'd1, '0, '0, '0));
      pending_reqs.push_back(make_req(pied_pkg::MODE_ENABLE, 3'd0, 30'h3FFF_FFFF,
                                      '0, '0, '0, '0));
      // mode codes with no meaning
      pending_reqs.push_back(make_req(3'd5, 3'd0, '0, '0, '0, '0, '0));
      pending_reqs.push_back(make_req(3'd7, 3'd7, '1, '1, '1, '1, '1));
      // fill the table, every level, shared all-ones masks
      for (int k = 0; k < DEPTH; k++)
         pending_reqs.push_back(make_req(pied_pkg::MODE_SUBSCRIBE, 3'(k % LEVELS), '0,
                                         '1, '1, '1, '1));
      // table full
      pending_reqs.push_back(make_req(pied_pkg::MODE_SUBSCRIBE, 3'd0, '0, '0, '0, '0, '0));
      // every entry hits
      pending_reqs.push_back(make_req(pied_pkg::MODE_INTERRUPT, 3'd0, '0, '1, '1, '1, '1));
      pending_reqs.push_back(make_req(pied_pkg::MODE_DISABLE, 3'd0, HW'(1),
                                      '0, '0, '0, '0));
      pending_reqs.push_back(make_req(pied_pkg::MODE_INTERRUPT, 3'd0, '0,
                                      32'h8000_0000, '0, '0, 32'd1));
      pending_reqs.push_back(make_req(pied_pkg::MODE_UNSUBSCRIBE, 3'd0, HW'(5),
                                      '0, '0, '0, '0));
      pending_reqs.push_back(make_req(pied_pkg::MODE_UNSUBSCRIBE, 3'd0, HW'(5),
                                      '0, '0, '0, '0));

      // random, biased toward well-formed subscribe/interrupt traffic
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 70) begin
            wait (pending_reqs.size() == 0);
            idle_phase = 1;
         end
         if (n == 140) begin
            wait (pending_reqs.size() == 0);
            idle_phase = 2;
         end
         pick = $urandom_range(99);
         q = make_req(pied_pkg::MODE_INTERRUPT, 3'($urandom), pick_handle(), sparse_word(),
                      sparse_word(), sparse_word(), sparse_word());
         if (pick < 25) begin
            q.mode = pied_pkg::MODE_SUBSCRIBE;
            if ($urandom_range(7) != 0) q.priority_req = 3'($urandom_range(LEVELS - 1));
         end else if (pick < 35) q.mode = pied_pkg::MODE_ENABLE;
         else if (pick < 45) q.mode = pied_pkg::MODE_DISABLE;
         else if (pick < 60) q.mode = pied_pkg::MODE_UNSUBSCRIBE;
         else if (pick < 97) q.mode = pied_pkg::MODE_INTERRUPT;
         else q.mode = 3'($urandom_range(5, 7));
         pending_reqs.push_back(q);
         @(posedge clock);
      end

      wait (pending_reqs.size() == 0 && !req_valid && expected_rsps.size() == 0);
      repeat (200) @(posedge clock);
      if (fail_count == 0 && expected_rsps.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
